[sv/tpad_pkg.sv]
// Shared types, constants and the power scaling table of the triac dimmer.
package tpad_pkg;

  localparam int unsigned WINDOW_TICKS = 10;
  localparam logic [6:0] MinPower = 7'd10;
  localparam logic [6:0] FullPower = 7'd100;
  localparam logic [7:0] LimitReset = 8'd120;

  // floor(x / 100) equals (x * RecipMul) >> RecipShift for every x below 2^15.
  localparam int unsigned RecipShift = 20;
  localparam int unsigned RecipMul = ((1 << RecipShift) + 99) / 100;

  typedef logic [RecipShift-1:0] scale_tab_t [128];

  function automatic scale_tab_t build_scale();
    scale_tab_t tab;
    for (int i = 0; i < 128; i++) begin
      tab[i] = RecipShift'(i * RecipMul);
    end
    return tab;
  endfunction

  // Power in percent, already multiplied by the reciprocal of 100; entries from 100 up wrap at RecipShift bits.
  localparam scale_tab_t PwrScale = build_scale();

  typedef struct packed {
    logic       ac_level;
    logic       heat_enable;
    logic [6:0] power_percent;
    logic       com_relay_on;
  } tpad_item_t;

  typedef struct packed {
    logic [7:0] tick_count;
    logic [7:0] measured_period;
    logic       prev_ac_level;
    logic       gate;
    logic       fan;
  } tpad_state_t;

  typedef struct packed {
    logic       gate_drive;
    logic       fan_drive;
    logic [7:0] half_period;
  } tpad_result_t;

endpackage

[sv/tpad_step.sv]
// Next-state and result logic for one sample tick of the triac dimmer.
module tpad_step (
  input  tpad_pkg::tpad_state_t  state,
  input  tpad_pkg::tpad_item_t   item,
  input  logic [7:0]             period_limit,
  output tpad_pkg::tpad_state_t  state_nxt,
  output tpad_pkg::tpad_result_t result
);
  import tpad_pkg::*;

  localparam int unsigned ProdW = RecipShift + 8;

  logic [8:0]       next_cnt;
  logic             timeout;
  logic             edge_hit;
  logic [7:0]       period_new;
  logic [7:0]       tick_cur;
  logic [ProdW-1:0] prod;
  logic [7:0]       quot;
  logic [7:0]       start;
  logic [8:0]       win_end;
  logic             in_window;

  assign next_cnt   = {1'b0, state.tick_count} + 9'd1;
  assign timeout    = next_cnt >= {1'b0, period_limit};
  assign edge_hit   = !state.prev_ac_level && item.ac_level;
  assign period_new = edge_hit ? next_cnt[7:0] : state.measured_period;
  assign tick_cur   = edge_hit ? 8'd0 : next_cnt[7:0];

  // Phase delay: start = D - floor(power * D / 100), with a single multiply.
  assign prod      = ProdW'(PwrScale[item.power_percent]) * ProdW'(period_new);
  assign quot      = prod[ProdW-1:RecipShift];
  assign start     = period_new - quot;
  assign win_end   = {1'b0, start} + 9'(WINDOW_TICKS);
  assign in_window = (tick_cur >= start) && ({1'b0, tick_cur} <= win_end);

  always_comb begin
    state_nxt = state;
    if (timeout) begin
      // AC lost: the edge detector is not sampled and the drives hold.
      state_nxt.tick_count      = 8'd0;
      state_nxt.measured_period = 8'd0;
    end else begin
      state_nxt.tick_count      = tick_cur;
      state_nxt.measured_period = period_new;
      state_nxt.prev_ac_level   = item.ac_level;
      if (!item.heat_enable || item.power_percent < MinPower) begin
        state_nxt.gate = 1'b0;
        if (item.com_relay_on) begin
          state_nxt.fan = 1'b0;
        end
      end else begin
        state_nxt.fan  = 1'b1;
        state_nxt.gate = (item.power_percent >= FullPower) ? 1'b1 : in_window;
      end
    end
  end

  assign result.gate_drive  = state_nxt.gate;
  assign result.fan_drive   = state_nxt.fan;
  assign result.half_period = state_nxt.measured_period;

endmodule

[sv/triac_phase_angle_dimmer_unit.sv]
// Top level of the triac phase-angle dimmer with AC half-period measurement.
//
// Input stream (in_*): one transaction per sample tick, carrying the zero-cross
// opto level, the heating enable, the power request and the common relay status.
// Output stream (out_*): one transaction per input tick with the gate drive, the
// fan drive and the last measured AC half period (0 when no AC is present).
// Configuration (cfg_*): a write sets period_limit; cfg_ready is always high.
// Write it only while no ticks are in flight.
//
// A tick passes from input acceptance to output valid through one input
// register, then the step logic (one 20x8 multiply, a subtract and compares)
// into the output register. One tick is accepted every cycle while the
// receiver keeps up. When the receiver stalls, the output holds and in_tready
// drops once the input register holds a tick.
//
// The synchronous reset clears the tick counter, the measured period, the edge
// detector and both drives, empties both registers and sets period_limit to 120.
module triac_phase_angle_dimmer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // ac_level, heat_enable, power_percent[6:0], com_relay_on
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // gate_drive, fan_drive, half_period[7:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data    // period_limit
);
  import tpad_pkg::*;

  logic         in_v_r;
  tpad_item_t   in_item_r;
  tpad_item_t   in_item;
  tpad_state_t  state_r;
  tpad_state_t  state_nxt;
  tpad_result_t result;
  logic         out_v_r;
  tpad_result_t out_res_r;
  logic [7:0]   limit_r;
  logic         fire;
  logic         in_accept;

  assign in_item.ac_level      = in_tdata[0];
  assign in_item.heat_enable   = in_tdata[1];
  assign in_item.power_percent = in_tdata[8:2];
  assign in_item.com_relay_on  = in_tdata[9];

  assign fire      = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || fire;
  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  tpad_step u_step (
    .state        (state_r),
    .item         (in_item_r),
    .period_limit (limit_r),
    .state_nxt    (state_nxt),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      state_r <= '0;
      limit_r <= LimitReset;
    end else begin
      if (fire) begin
        in_v_r <= 1'b0;
      end
      if (in_accept) begin
        in_v_r <= 1'b1;
      end
      if (fire) begin
        out_v_r <= 1'b1;
        state_r <= state_nxt;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
      if (cfg_valid) begin
        limit_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_item_r <= in_item;
    end
    if (fire) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'd0, out_res_r.half_period, out_res_r.fan_drive, out_res_r.gate_drive};

endmodule

[sv/tpad_checker.sv]
// Port-level checker for the triac dimmer and its bind to the top level.
module tpad_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // A stalled result transaction keeps its data.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");

  // The gate is only ever fired with the fan running.
  a_gate_fan: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[1])
    else $error("gate on with fan off");

  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:10] == 6'd0)
    else $error("output padding not zero");

  // With the output side empty the input register can always drain.
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

endmodule

bind triac_phase_angle_dimmer_unit tpad_checker u_tpad_checker (.*);

[verif/triac_phase_angle_dimmer_unit_test.sv]
// Self-checking testbench for the triac phase-angle dimmer unit.
`timescale 1ns / 1ps

module triac_phase_angle_dimmer_unit_test;
  import tpad_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD = 100;

  typedef struct packed {
    logic       ac;
    logic       en;
    logic [6:0] pwr;
    logic       com;
    logic       typed;
    logic       gate;
    logic       fan;
    logic [7:0] hp;
  } tick_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;

  // Shadow copy of the dimmer state and its period limit.
  int unsigned  ac_limit = LimitReset;
  int unsigned  tick_cnt = 0;
  int unsigned  half_per = 0;
  logic         last_ac = 1'b0;
  logic         gate_q = 1'b0;
  logic         fan_q = 1'b0;

  tpad_result_t pending_drives[$];
  tpad_result_t got_drive, want_drive;
  int           mismatches = 0;
  int           results_seen = 0;
  int           stall_cycles = 0;
  int           tx_idle_pct = 0;
  int           rx_idle_pct = 0;
  bit           quiet_tail = 1'b0;
  bit           long_hold_done = 1'b0;

  // Directed ticks at the reset limit; rows marked typed carry their expected drive.
  tick_row_t dir_rows [0:21] = '{
    '{0, 0,   0, 0, 1, 0, 0, 0},
    '{0, 1, 100, 0, 1, 1, 1, 0},
    '{0, 1, 127, 1, 1, 1, 1, 0},
    '{0, 0, 127, 0, 1, 0, 1, 0},
    '{0, 1,   9, 1, 1, 0, 0, 0},
    '{1, 1,   0, 0, 1, 0, 0, 6},
    '{1, 1,  10, 0, 1, 0, 1, 6},
    '{0, 1,  50, 0, 0, 0, 0, 0},
    '{0, 1,  75, 0, 0, 0, 0, 0},
    '{0, 1,  99, 1, 0, 0, 0, 0},
    '{1, 1,  50, 0, 0, 0, 0, 0},
    '{1, 1,  25, 0, 0, 0, 0, 0},
    '{0, 1,  10, 0, 0, 0, 0, 0},
    '{0, 1,  90, 1, 0, 0, 0, 0},
    '{0, 0,  90, 0, 0, 0, 0, 0},
    '{1, 1,  11, 1, 0, 0, 0, 0},
    '{0, 1,  64, 0, 0, 0, 0, 0},
    '{1, 1, 127, 0, 0, 0, 0, 0},
    '{0, 1,  63, 1, 0, 0, 0, 0},
    '{1, 1,  99, 0, 0, 0, 0, 0},
    '{1, 0,   0, 1, 0, 0, 0, 0},
    '{0, 1, 100, 0, 0, 0, 0, 0}
  };

  triac_phase_angle_dimmer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // Advances the shadow state by one sample tick and returns the drives it produces.
  function automatic tpad_result_t dimmer_tick(input logic ac, input logic en,
                                               input logic [6:0] pwr, input logic com);
    int unsigned  nxt;
    int unsigned  pwr_u;
    int unsigned  start_pos;
    tpad_result_t r;
    nxt = tick_cnt + 1;
    pwr_u = pwr;
    if (nxt >= ac_limit) begin
      // AC deemed lost: the edge detector is not sampled and the drives hold.
      half_per = 0;
      tick_cnt = 0;
    end else begin
      tick_cnt = nxt;
      if (!last_ac && ac) begin
        half_per = tick_cnt;
        tick_cnt = 0;
      end
      last_ac = ac;
      if (!en || pwr < MinPower) begin
        gate_q = 1'b0;
        if (com) fan_q = 1'b0;
      end else begin
        fan_q = 1'b1;
        if (pwr >= FullPower) begin
          gate_q = 1'b1;
        end else begin
          start_pos = half_per - (pwr_u * half_per) / FullPower;
          gate_q = (tick_cnt >= start_pos) && (tick_cnt <= start_pos + WINDOW_TICKS);
        end
      end
    end
    r.gate_drive = gate_q;
    r.fan_drive = fan_q;
    r.half_period = half_per[7:0];
    return r;
  endfunction

  // Offers one tick, at times after a random gap, and records its expected drives once accepted.
  task automatic send_tick(input logic ac, input logic en, input logic [6:0] pwr,
                           input logic com, input bit use_typed, input tpad_result_t typed);
    tpad_result_t predicted;
    if (!quiet_tail && $urandom_range(0, 99) < tx_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15) - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {6'b0, com, pwr, en, ac};
    do @(posedge clk); while (!in_tready);
    predicted = dimmer_tick(ac, en, pwr, com);
    pending_drives.push_back(use_typed ? typed : predicted);
  endtask

  task automatic drain_drives();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [7:0] lim);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= lim;
    do @(posedge clk); while (!cfg_ready);
    ac_limit = lim;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly square waves of random period and duty with mostly steady settings, plus noise ticks.
  task automatic random_ticks(input int n);
    int         done;
    int         per;
    int         hi;
    int         reps;
    logic       en;
    logic [6:0] pwr;
    logic       com;
    done = 0;
    while (done < n) begin
      if ($urandom_range(0, 99) < 75) begin
        if (ac_limit >= 4 && $urandom_range(0, 9) < 8) per = $urandom_range(2, ac_limit - 1);
        else per = $urandom_range(2, 255);
        hi = $urandom_range(1, per - 1);
        reps = $urandom_range(1, 3);
        en = ($urandom_range(0, 9) != 0);
        pwr = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                          : 7'($urandom_range(10, 99));
        com = 1'($urandom_range(0, 1));
        for (int r = 0; r < reps && done < n; r++) begin
          for (int t = 0; t < per && done < n; t++) begin
            if ($urandom_range(0, 15) == 0) pwr = 7'($urandom_range(0, 127));
            if ($urandom_range(0, 15) == 0) com = ~com;
            send_tick(t >= per - hi, en, pwr, com, 1'b0, '0);
            done++;
          end
        end
      end else begin
        repeat ($urandom_range(1, 10)) begin
          send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)), 1'b0, '0);
          done++;
        end
      end
    end
  endtask

  // Result side: random back-pressure and one long hold-off so the input stalls.
  initial begin
    forever begin
      @(negedge clk);
      if (!long_hold_done && results_seen >= 350) begin
        long_hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (!quiet_tail && $urandom_range(0, 99) < rx_idle_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15) - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      got_drive.gate_drive = out_tdata[0];
      got_drive.fan_drive = out_tdata[1];
      got_drive.half_period = out_tdata[9:2];
      if (pending_drives.size() == 0) begin
        $display("%0t: unexpected transaction gate=%0d fan=%0d half_period=%0d", $time,
                 got_drive.gate_drive, got_drive.fan_drive, got_drive.half_period);
        mismatches++;
      end else begin
        want_drive = pending_drives.pop_front();
        if (got_drive.gate_drive !== want_drive.gate_drive) begin
          $display("%0t: gate_drive expected %0d actual %0d", $time,
                   want_drive.gate_drive, got_drive.gate_drive);
          mismatches++;
        end
        if (got_drive.fan_drive !== want_drive.fan_drive) begin
          $display("%0t: fan_drive expected %0d actual %0d", $time,
                   want_drive.fan_drive, got_drive.fan_drive);
          mismatches++;
        end
        if (got_drive.half_period !== want_drive.half_period) begin
          $display("%0t: half_period expected %0d actual %0d", $time,
                   want_drive.half_period, got_drive.half_period);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [7:0] limits [0:9];
    limits = '{8'd255, 8'd2, 8'd1, 8'd0, 8'd40, 8'd12, 8'd120,
               8'($urandom_range(2, 255)), 8'($urandom_range(2, 255)), 8'd254};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      send_tick(dir_rows[i].ac, dir_rows[i].en, dir_rows[i].pwr, dir_rows[i].com,
                dir_rows[i].typed, {dir_rows[i].gate, dir_rows[i].fan, dir_rows[i].hp});
    end

    tx_idle_pct = 20;
    rx_idle_pct = 20;
    random_ticks(60);
    // Let the pipeline run empty once in the middle of a stream.
    drain_drives();
    random_ticks(70);

    for (int ph = 0; ph < 10; ph++) begin
      drain_drives();
      repeat (4) @(posedge clk);
      write_limit(limits[ph]);
      tx_idle_pct = (ph % 3 == 0) ? 0 : $urandom_range(5, 40);
      rx_idle_pct = (ph % 3 == 1) ? 0 : $urandom_range(5, 40);
      if (ph == 9) quiet_tail = 1'b1;
      random_ticks(125);
    end

    drain_drives();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_drives.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
